// ----- hw/rtl/clock_string_to_unix_time_assert.svh -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: assertion macros
// Concurrent assertion wrappers used by the field queue RTL. With SYNTH defined
// the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CLOCK_STRING_TO_UNIX_TIME_ASSERT_SVH
`define CLOCK_STRING_TO_UNIX_TIME_ASSERT_SVH

`ifndef SYNTH

// Checked on every rising edge outside of reset.
`define CTU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/ctu_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: package
// Widths, character codes, date constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctu_pkg;

    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 5;
    localparam int TS_W    = 32;

    localparam int CTU_QUEUE_DEPTH = 4;

    localparam logic [POS_W-1:0] POS_MAX       = 5'd31;
    localparam logic [POS_W-1:0] ZONE_SIGN_POS = 5'd18;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;

    localparam logic [TS_W-1:0] EPOCH_2000      = 32'd946684800;
    localparam logic [TS_W-1:0] SEC_PER_DAY     = 32'd86400;
    localparam logic [16:0]     SEC_PER_QUARTER = 17'd900;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_ZONE
    } t_field;

    typedef struct packed {
        t_field field;
        logic   first;
    } t_slot;

    typedef struct packed {
        logic [FIELD_W-1:0] year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] zone;
        logic               ahead;
    } t_fields;

    typedef struct packed {
        logic    push;
        t_fields fields;
    } t_push;

    typedef struct packed {
        logic    valid;
        t_fields fields;
    } t_queue_out;

    // Which field a string position feeds, and whether it is the first digit.
    function automatic t_slot slot_of(input logic [POS_W-1:0] pos);
        t_slot s;
        s.field = FLD_NONE;
        s.first = 1'b0;
        case (pos)
            5'd1:  begin s.field = FLD_YEAR;   s.first = 1'b1; end
            5'd2:  begin s.field = FLD_YEAR;   end
            5'd4:  begin s.field = FLD_MONTH;  s.first = 1'b1; end
            5'd5:  begin s.field = FLD_MONTH;  end
            5'd7:  begin s.field = FLD_DAY;    s.first = 1'b1; end
            5'd8:  begin s.field = FLD_DAY;    end
            5'd10: begin s.field = FLD_HOUR;   s.first = 1'b1; end
            5'd11: begin s.field = FLD_HOUR;   end
            5'd13: begin s.field = FLD_MINUTE; s.first = 1'b1; end
            5'd14: begin s.field = FLD_MINUTE; end
            5'd16: begin s.field = FLD_SECOND; s.first = 1'b1; end
            5'd17: begin s.field = FLD_SECOND; end
            5'd19: begin s.field = FLD_ZONE;   s.first = 1'b1; end
            5'd20: begin s.field = FLD_ZONE;   end
            default: begin s.field = FLD_NONE; end
        endcase
        return s;
    endfunction

    // Days in the year before the first of a month, month index 0 to 11.
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ctu_if.sv -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: channel interfaces
// Valid/ready channels for the character stream and the timestamp results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ctu_char_if import ctu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

interface ctu_time_if import ctu_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink (input valid, input timestamp, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ctu_front.sv -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: string parser
// Takes one character per transfer, accumulates the two-digit fields at their
// fixed positions and hands the finished field set to the queue on the last
// character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctu_front import ctu_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctu_char_if.sink      i_chr,
    input  logic          i_full,
    output t_push         o_push
);

    logic [POS_W-1:0]   r_position, n_position;
    t_fields            r_f, n_f;
    logic               r_stopped, n_stopped;

    logic               w_accept;
    t_slot              w_slot;
    logic [FIELD_W-1:0] w_cur;
    logic [FIELD_W-1:0] w_base;
    logic [FIELD_W-1:0] w_acc;
    logic [FIELD_W-1:0] w_new;
    logic               w_stop_in;
    logic               w_is_digit;

    assign i_chr.ready = !i_full;
    assign w_accept    = i_chr.valid && i_chr.ready;

    always_comb begin
        w_slot     = slot_of(r_position);
        n_f        = r_f;
        n_stopped  = r_stopped;
        case (w_slot.field)
            FLD_YEAR:   w_cur = r_f.year;
            FLD_MONTH:  w_cur = r_f.month;
            FLD_DAY:    w_cur = r_f.day;
            FLD_HOUR:   w_cur = r_f.hour;
            FLD_MINUTE: w_cur = r_f.minute;
            FLD_SECOND: w_cur = r_f.second;
            FLD_ZONE:   w_cur = r_f.zone;
            default:    w_cur = '0;
        endcase

        // The first digit position restarts its field like a fresh atoi call.
        w_base     = w_slot.first ? '0 : w_cur;
        w_stop_in  = w_slot.first ? 1'b0 : r_stopped;
        w_is_digit = i_chr.character inside {[CHAR_ZERO:CHAR_NINE]};
        w_acc      = FIELD_W'(({4'b0, w_base} << 3) + ({4'b0, w_base} << 1)
                              + 11'(i_chr.character[3:0]));
        w_new      = (!w_stop_in && w_is_digit) ? w_acc : w_base;

        if (w_slot.field != FLD_NONE) begin
            n_stopped = w_stop_in || !w_is_digit;
        end

        case (w_slot.field)
            FLD_YEAR:   n_f.year   = w_new;
            FLD_MONTH:  n_f.month  = w_new;
            FLD_DAY:    n_f.day    = w_new;
            FLD_HOUR:   n_f.hour   = w_new;
            FLD_MINUTE: n_f.minute = w_new;
            FLD_SECOND: n_f.second = w_new;
            FLD_ZONE:   n_f.zone   = w_new;
            default:    ;
        endcase

        if (r_position == ZONE_SIGN_POS) begin
            n_f.ahead = (i_chr.character == CHAR_PLUS);
        end

        n_position = (r_position != POS_MAX) ? r_position + 1'b1 : r_position;
    end

    // The last character is folded in before the field set leaves.
    assign o_push.push   = w_accept && i_chr.last;
    assign o_push.fields = n_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_f        <= '0;
            r_stopped  <= 1'b0;
        end else if (w_accept) begin
            if (i_chr.last) begin
                r_position <= '0;
                r_f        <= '0;
                r_stopped  <= 1'b0;
            end else begin
                r_position <= n_position;
                r_f        <= n_f;
                r_stopped  <= n_stopped;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ctu_queue.sv -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: field queue
// Small FIFO of parsed field sets between the parser and the date datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "clock_string_to_unix_time_assert.svh"

module ctu_queue import ctu_pkg::*; #(
    parameter int DEPTH = CTU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_full,
    output t_queue_out o_head,
    input  logic       i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_fields          r_mem [DEPTH];
    t_fields          r_head;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_push;
    logic w_pop;
    logic w_empty;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_push  = i_push.push && !o_full;
    assign w_pop   = i_pop && !w_empty;

    assign o_head.valid  = !w_empty;
    assign o_head.fields = r_head;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The head register follows the next read pointer; an entry written in the
    // same cycle that it becomes the head is taken straight from the input.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.fields;
        end
        if (w_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_push.fields;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    `CTU_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(i_push.push && o_full), "queue push while full")
    `CTU_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, !(i_pop && w_empty), "queue pop while empty")
    `CTU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `CTU_ASSERT(a_count_tracks, i_clk, i_rst_n, (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not follow a push")

endmodule

`default_nettype wire

// ----- hw/rtl/ctu_back.sv -----
// ----------------------------------------------------------------------------
// Clock string to Unix time: date datapath
// Four-stage pipeline from a parsed field set to the UTC timestamp, with the
// last stage serving as the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctu_back import ctu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_head,
    output logic       o_pop,
    ctu_time_if.source o_time
);

    logic               w_advance;

    // Stage 1: day count, hours and minutes, zone seconds.
    logic               r_s1_valid;
    logic signed [17:0] r_s1_days;
    logic [12:0]        r_s1_hm;
    logic [FIELD_W-1:0] r_s1_sec;
    logic [16:0]        r_s1_zone;
    logic               r_s1_ahead;

    // Stage 2: seconds of whole days, seconds within the day.
    logic               r_s2_valid;
    logic [TS_W-1:0]    r_s2_dsec;
    logic [18:0]        r_s2_hms;
    logic [16:0]        r_s2_zone;
    logic               r_s2_ahead;

    // Stage 3: epoch-based day seconds and the signed day offset.
    logic               r_s3_valid;
    logic [TS_W-1:0]    r_s3_base;
    logic [TS_W-1:0]    r_s3_off;

    logic               r_out_valid;
    logic [TS_W-1:0]    r_out_ts;

    logic [3:0]         w_month;
    logic [15:0]        w_y365;
    logic [5:0]         w_quad;
    logic               w_leap;
    logic [16:0]        w_days_u;
    logic signed [17:0] n_s1_days;

    assign w_advance    = !r_out_valid || o_time.ready;
    assign o_pop        = i_head.valid && w_advance;
    assign o_time.valid = r_out_valid;
    assign o_time.timestamp = r_out_ts;

    always_comb begin
        // Month 0 counts as January and anything past December as December.
        if (i_head.fields.month == '0) begin
            w_month = 4'd1;
        end else if (i_head.fields.month > 7'd12) begin
            w_month = 4'd12;
        end else begin
            w_month = i_head.fields.month[3:0];
        end
        w_y365    = 16'(i_head.fields.year) * 16'd365;
        w_quad    = 6'((8'(i_head.fields.year) + 8'd3) >> 2);
        w_leap    = (w_month > 4'd2) && (i_head.fields.year[1:0] == 2'b00);
        w_days_u  = 17'(w_y365) + 17'(w_quad) + 17'(days_before_month(w_month - 4'd1))
                  + 17'(w_leap) + 17'(i_head.fields.day);
        n_s1_days = $signed({1'b0, w_days_u}) - 18'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid  <= i_head.valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_days  <= n_s1_days;
            r_s1_hm    <= 13'(i_head.fields.hour) * 13'd60 + 13'(i_head.fields.minute);
            r_s1_sec   <= i_head.fields.second;
            r_s1_zone  <= 17'(i_head.fields.zone) * SEC_PER_QUARTER;
            r_s1_ahead <= i_head.fields.ahead;

            r_s2_dsec  <= {{(TS_W - 18){r_s1_days[17]}}, r_s1_days} * SEC_PER_DAY;
            r_s2_hms   <= 19'(r_s1_hm) * 19'd60 + 19'(r_s1_sec);
            r_s2_zone  <= r_s1_zone;
            r_s2_ahead <= r_s1_ahead;

            r_s3_base  <= r_s2_dsec + EPOCH_2000;
            r_s3_off   <= r_s2_ahead ? (TS_W'(r_s2_hms) - TS_W'(r_s2_zone))
                                     : (TS_W'(r_s2_hms) + TS_W'(r_s2_zone));

            r_out_ts   <= r_s3_base + r_s3_off;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clock_string_to_unix_time.sv -----
// The finished field set passes the field queue and the s1, s2, s3 and output registers.
// One character per cycle and one field set per cycle while the output is not stalled.
// The parser stalls only when the field queue is full behind a stalled output.
// Reset (i_rst_n low, synchronous) empties the queue and pipeline and clears the parser.
// ----------------------------------------------------------------------------
// Clock string to Unix time: top level
// Converts a "yy/MM/dd,hh:mm:ss+zz" character stream into a UTC Unix time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_string_to_unix_time import ctu_pkg::*; #(
    parameter int QUEUE_DEPTH = CTU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctu_char_if.sink   i_chr,
    ctu_time_if.source o_time
);

    t_push      w_push;
    logic       w_full;
    t_queue_out w_head;
    logic       w_pop;

    ctu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (i_chr),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    ctu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    ctu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_time  (o_time)
    );

endmodule

`default_nettype wire
